// ----- hdl/bre_pkg.sv -----
// Shared types and constants of the bitmap range engine.
`timescale 1ns / 1ps

package bre_pkg;

    // Bit index, byte index and result widths
    localparam int BIT_W  = 10;
    localparam int BYTE_W = 7;
    localparam int CNT_W  = 9;
    localparam int POS_W  = 8;

    // Command codes
    typedef enum logic [2:0] {
        OP_COUNT_ONES  = 3'd0,
        OP_COUNT_ZEROS = 3'd1,
        OP_SEARCH_UP   = 3'd2,
        OP_SEARCH_DOWN = 3'd3,
        OP_WRITE_RUN   = 3'd4,
        OP_FLIP_RUN    = 3'd5,
        OP_SET_ALL     = 3'd6,
        OP_CLEAR_ALL   = 3'd7
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Command context handed to the byte lane: bit range [lo, hi)
    typedef struct packed {
        op_t              op;
        logic             val;
        logic [BIT_W-1:0] lo;
        logic [BIT_W-1:0] hi;
    } lane_ctl_t;

    // What the byte lane makes of one stored byte
    typedef struct packed {
        logic       any;
        logic [2:0] low_bit;
        logic [2:0] high_bit;
        logic [3:0] ones;
        logic [7:0] new_byte;
    } lane_res_t;

endpackage

// ----- hdl/bitmap_range_engine.sv -----
// Top level of the bitmap range engine: bit_count register, sequencer, byte lane and bit store.
`timescale 1ns / 1ps

// Bitmap range engine. Holds an NBITS-bit array in a byte-wide synchronous RAM,
// of which the first bit_count bits are in use (bit i in byte i/8, bit i%8).
// Each command yields one result. The sequencer walks the store one byte per
// cycle through the single RAM read port, writing modified bytes back on the
// cycle after each read. A command touches ceil(n/8) bytes for counts, set all
// and clear all, the bytes of the run for runs, and up to ceil(n/8) for
// searches, which stop at the first byte that holds a match. Refused runs and
// empty searches read no byte. After reset a clearing pass zeroes the first
// min(ceil(NBITS/8), 64) bytes of the store, during which in_ready stays low.
// cfg_ready is always high; write bit_count only while no command is in flight.
// A bit_count above NBITS acts as NBITS.
module bitmap_range_engine
    import bre_pkg::*;
#(
    parameter int NBITS = 256
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [8:0]       cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       operation,
    input  logic [9:0]       index,
    input  logic [8:0]       run_length,
    input  logic             bit_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             found,
    output logic [7:0]       position,
    output logic [8:0]       tally,
    output logic             accepted
);

    localparam int DEPTH  = (NBITS + 7) / 8;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NCAP   = (NBITS < 511) ? NBITS : 511;
    localparam int NRESET = (NBITS < 256) ? NBITS : 256;

    logic [CNT_W-1:0]  used_reg, used_next;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [7:0]        mem_rdata;
    lane_ctl_t         lane_ctl;
    logic [BYTE_W-1:0] lane_addr;
    lane_res_t         lane_res;

    // Hold the number of bits in use, clamped to the array size
    assign cfg_ready = 1'b1;

    always_comb
    begin
        used_next = used_reg;
        if (cfg_valid)
        begin
            used_next = (cfg_data > CNT_W'(NCAP)) ? CNT_W'(NCAP) : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= CNT_W'(NRESET);
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    bre_seq #(
        .NBITS (NBITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .used_bits  (used_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .index      (index),
        .run_length (run_length),
        .bit_value  (bit_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .position   (position),
        .tally      (tally),
        .accepted   (accepted),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .lane_ctl   (lane_ctl),
        .lane_addr  (lane_addr),
        .lane_res   (lane_res)
    );

    bre_lane u_lane (
        .ctl  (lane_ctl),
        .addr (lane_addr),
        .data (mem_rdata),
        .res  (lane_res)
    );

    bre_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- hdl/bre_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module bre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bre_lane.sv -----
// Byte lane: range mask, population count, bit search and modify of one stored byte.
`timescale 1ns / 1ps

module bre_lane
    import bre_pkg::*;
(
    input  lane_ctl_t         ctl,
    input  logic [BYTE_W-1:0] addr,
    input  logic [7:0]        data,
    output lane_res_t         res
);

    logic [BIT_W-1:0] pos_w;
    logic [7:0]       mask;
    logic [7:0]       sel;
    logic [7:0]       masked;
    logic             pick;

    always_comb
    begin
        // Mark the bits of this byte that lie inside [lo, hi)
        mask = '0;
        for (int b = 0; b < 8; b++)
        begin
            pos_w   = {addr, 3'(b)};
            mask[b] = (pos_w >= ctl.lo) && (pos_w < ctl.hi);
        end

        // Look at ones for a count of ones or a search for ones, else at zeros
        pick = (ctl.op == OP_COUNT_ONES) ||
               (((ctl.op == OP_SEARCH_UP) || (ctl.op == OP_SEARCH_DOWN)) && ctl.val);
        sel    = pick ? data : ~data;
        masked = sel & mask;

        res = '0;
        res.any = |masked;

        // Count the matching bits
        for (int b = 0; b < 8; b++)
        begin
            res.ones = res.ones + 4'(masked[b]);
        end

        // Lowest matching bit
        for (int b = 7; b >= 0; b--)
        begin
            if (masked[b])
            begin
                res.low_bit = 3'(b);
            end
        end

        // Highest matching bit
        for (int b = 0; b < 8; b++)
        begin
            if (masked[b])
            begin
                res.high_bit = 3'(b);
            end
        end

        // Modified byte for the writing commands
        unique case (ctl.op)
            OP_WRITE_RUN: res.new_byte = ctl.val ? (data | mask) : (data & ~mask);
            OP_FLIP_RUN:  res.new_byte = data ^ mask;
            OP_SET_ALL:   res.new_byte = data | mask;
            OP_CLEAR_ALL: res.new_byte = data & ~mask;
            default:      res.new_byte = data;
        endcase
    end

endmodule

// ----- hdl/bre_seq.sv -----
// Command sequencer: clearing pass, byte walk over the store, read-modify-write, result register.
`timescale 1ns / 1ps

module bre_seq
    import bre_pkg::*;
#(
    parameter int NBITS = 256,
    localparam int DEPTH = (NBITS + 7) / 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  used_bits,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        operation,
    input  logic [BIT_W-1:0]  index,
    input  logic [CNT_W-1:0]  run_length,
    input  logic              bit_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              found,
    output logic [POS_W-1:0]  position,
    output logic [CNT_W-1:0]  tally,
    output logic              accepted,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [7:0]        mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    output lane_ctl_t         lane_ctl,
    output logic [BYTE_W-1:0] lane_addr,
    input  lane_res_t         lane_res
);

    // Only the first 511 bits can ever be in use
    localparam int CLR_DEPTH = (DEPTH < 64) ? DEPTH : 64;

    state_t            state_reg,       state_next;
    op_t               op_reg,          op_next;
    logic              val_reg,         val_next;
    logic [BIT_W-1:0]  lo_reg,          lo_next;
    logic [BIT_W-1:0]  hi_reg,          hi_next;
    logic              acc_reg,         acc_next;
    logic              down_reg,        down_next;
    logic [BYTE_W-1:0] cur_reg,         cur_next;
    logic [BYTE_W-1:0] end_reg,         end_next;
    logic              issue_done_reg,  issue_done_next;
    logic              vld_reg,         vld_next;
    logic [BYTE_W-1:0] vaddr_reg,       vaddr_next;
    logic              hit_reg,         hit_next;
    logic [POS_W-1:0]  pos_reg,         pos_next;
    logic [CNT_W-1:0]  cnt_reg,         cnt_next;
    logic              out_valid_reg,   out_valid_next;
    logic              found_reg;
    logic [POS_W-1:0]  position_reg;
    logic [CNT_W-1:0]  tally_reg;
    logic              accepted_reg;
    logic              out_load;

    // Command decode at acceptance
    op_t               op_in;
    logic [BIT_W-1:0]  n_w;
    logic [BIT_W:0]    sum_w;
    logic              run_ok;
    logic [BIT_W-1:0]  down_start;
    logic [BIT_W-1:0]  lo_in;
    logic [BIT_W-1:0]  hi_in;
    logic [BIT_W-1:0]  hi_m1;
    logic              acc_in;
    logic              empty_in;

    always_comb
    begin
        op_in      = op_t'(operation);
        n_w        = {1'b0, used_bits};
        sum_w      = {1'b0, index} + {2'b00, run_length};
        run_ok     = (run_length != '0) && (index < n_w) && (sum_w <= {2'b00, used_bits});
        down_start = (index >= n_w) ? (n_w - 10'd1) : index;
        lo_in      = '0;
        hi_in      = n_w;
        acc_in     = 1'b0;
        unique case (op_in)
            OP_COUNT_ONES, OP_COUNT_ZEROS:
            begin
                lo_in = '0;
                hi_in = n_w;
            end
            OP_SEARCH_UP:
            begin
                lo_in = index;
                hi_in = n_w;
            end
            OP_SEARCH_DOWN:
            begin
                lo_in = '0;
                hi_in = (used_bits == '0) ? '0 : (down_start + 10'd1);
            end
            OP_WRITE_RUN, OP_FLIP_RUN:
            begin
                lo_in  = run_ok ? index : '0;
                hi_in  = run_ok ? sum_w[BIT_W-1:0] : '0;
                acc_in = run_ok;
            end
            OP_SET_ALL, OP_CLEAR_ALL:
            begin
                lo_in  = '0;
                hi_in  = n_w;
                acc_in = 1'b1;
            end
        endcase
        empty_in = (hi_in <= lo_in);
        hi_m1    = hi_in - 10'd1;
    end

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        acc_next        = acc_reg;
        down_next       = down_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        issue_done_next = issue_done_reg;
        vld_next        = vld_reg;
        vaddr_next      = vaddr_reg;
        hit_next        = hit_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_load        = 1'b0;
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = AW'(cur_reg);
        mem_wdata       = '0;
        mem_raddr       = AW'(cur_reg);
        lane_addr       = vaddr_reg;
        lane_ctl        = '{op: op_reg, val: val_reg, lo: lo_reg, hi: hi_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero the store one byte a cycle
                mem_we = 1'b1;
                if (cur_reg == BYTE_W'(CLR_DEPTH - 1))
                begin
                    cur_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + 7'd1;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next         = op_in;
                    val_next        = bit_value;
                    lo_next         = lo_in;
                    hi_next         = hi_in;
                    acc_next        = acc_in;
                    down_next       = (op_in == OP_SEARCH_DOWN);
                    cur_next        = (op_in == OP_SEARCH_DOWN) ? hi_m1[BIT_W-1:3]
                                                                 : lo_in[BIT_W-1:3];
                    end_next        = (op_in == OP_SEARCH_DOWN) ? lo_in[BIT_W-1:3]
                                                                 : hi_m1[BIT_W-1:3];
                    issue_done_next = empty_in;
                    vld_next        = 1'b0;
                    hit_next        = 1'b0;
                    pos_next        = '0;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Consume the byte read last cycle
                if (vld_reg)
                begin
                    unique case (op_reg)
                        OP_COUNT_ONES, OP_COUNT_ZEROS:
                        begin
                            cnt_next = cnt_reg + CNT_W'(lane_res.ones);
                        end
                        OP_SEARCH_UP:
                        begin
                            if (lane_res.any)
                            begin
                                hit_next = 1'b1;
                                pos_next = POS_W'({vaddr_reg, lane_res.low_bit});
                            end
                        end
                        OP_SEARCH_DOWN:
                        begin
                            if (lane_res.any)
                            begin
                                hit_next = 1'b1;
                                pos_next = POS_W'({vaddr_reg, lane_res.high_bit});
                            end
                        end
                        OP_WRITE_RUN, OP_FLIP_RUN, OP_SET_ALL, OP_CLEAR_ALL:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(vaddr_reg);
                            mem_wdata = lane_res.new_byte;
                        end
                    endcase
                end

                // Stop on a hit or once the last byte is consumed; else issue the next read
                if (hit_next || issue_done_reg)
                begin
                    vld_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    vld_next   = 1'b1;
                    vaddr_next = cur_reg;
                    if (cur_reg == end_reg)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else if (down_reg)
                    begin
                        cur_next = cur_reg - 7'd1;
                    end
                    else
                    begin
                        cur_next = cur_reg + 7'd1;
                    end
                end
            end
            ST_FINISH:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cur_reg        <= '0;
            issue_done_reg <= 1'b0;
            vld_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            down_reg       <= 1'b0;
            op_reg         <= OP_COUNT_ONES;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            issue_done_reg <= issue_done_next;
            vld_reg        <= vld_next;
            out_valid_reg  <= out_valid_next;
            down_reg       <= down_next;
            op_reg         <= op_next;
        end
    end

    // Command context and payload
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        acc_reg   <= acc_next;
        end_reg   <= end_next;
        vaddr_reg <= vaddr_next;
        hit_reg   <= hit_next;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        if (out_load)
        begin
            found_reg    <= hit_reg;
            position_reg <= pos_reg;
            tally_reg    <= cnt_reg;
            accepted_reg <= acc_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;
    assign tally     = tally_reg;
    assign accepted  = accepted_reg;

`ifndef SYNTHESIS
    // A write-back never hits the byte being read in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && mem_we && !issue_done_reg && !hit_next)
            |-> (mem_waddr != mem_raddr))
        else $error("write-back and read address clash");

    // No read is in flight outside the scan
    a_vld_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (state_reg == ST_SCAN))
        else $error("byte pending outside scan");

    // An accepted command starts a scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SCAN))
        else $error("accepted command did not start a scan");

    // A finished command presents its result in the next cycle
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("finished result not presented");

    // No command is taken during the clearing pass
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("command taken during clearing pass");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the bitmap range engine.
`timescale 1ns / 1ps

module testbench;
    import bre_pkg::*;

    localparam int NBITS         = 256;
    localparam int SETTLE_CYCLES = 80;
    localparam int REPORT_LIMIT  = 10;

    // One result as the block returns it
    typedef struct packed {
        logic       found;
        logic [7:0] position;
        logic [8:0] tally;
        logic       accepted;
    } answer_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic [8:0] cfg_data   = '0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [2:0] operation  = OP_COUNT_ONES;
    logic [9:0] index      = '0;
    logic [8:0] run_length = '0;
    logic       bit_value  = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic       found;
    logic [7:0] position;
    logic [8:0] tally;
    logic       accepted;

    // Predictor state: the bit array and the bit_count register
    logic [NBITS-1:0] model_bits      = '0;
    logic [8:0]       model_bit_count = 9'd256;

    answer_t pending_answers[$];
    int      failures      = 0;
    int      results_seen  = 0;
    int      cfg_writes    = 0;
    int      op_seen[8]    = '{default: 0};
    bit      steady_flow   = 1'b0;

    bitmap_range_engine #(.NBITS(NBITS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .index      (index),
        .run_length (run_length),
        .bit_value  (bit_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .position   (position),
        .tally      (tally),
        .accepted   (accepted)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic int bits_in_use();
        return (model_bit_count > NBITS) ? NBITS : int'(model_bit_count);
    endfunction

    // Work out the result of one command and update the bit array
    function automatic answer_t apply_command(input op_t op, input logic [9:0] idx,
                                              input logic [8:0] len, input logic val);
        answer_t ans;
        int      n;
        int      i;
        int      first;
        int      span;
        ans   = '0;
        n     = bits_in_use();
        first = int'(idx);
        span  = int'(len);
        case (op)
            OP_COUNT_ONES, OP_COUNT_ZEROS:
            begin
                for (i = 0; i < n; i++)
                    if (model_bits[i] == (op == OP_COUNT_ONES))
                        ans.tally = ans.tally + 1'b1;
            end
            OP_SEARCH_UP:
            begin
                for (i = first; i < n && !ans.found; i++)
                    if (model_bits[i] == val)
                    begin
                        ans.found    = 1'b1;
                        ans.position = i[7:0];
                    end
            end
            OP_SEARCH_DOWN:
            begin
                // clamp the start to the last bit in use
                if (n > 0)
                begin
                    if (first >= n)
                        first = n - 1;
                    for (i = first; i >= 0 && !ans.found; i--)
                        if (model_bits[i] == val)
                        begin
                            ans.found    = 1'b1;
                            ans.position = i[7:0];
                        end
                end
            end
            OP_WRITE_RUN, OP_FLIP_RUN:
            begin
                // refuse empty runs and runs that pass the last bit in use
                if (span != 0 && span <= n && first < n && first + span <= n)
                begin
                    for (i = first; i < first + span; i++)
                        model_bits[i] = (op == OP_FLIP_RUN) ? ~model_bits[i] : val;
                    ans.accepted = 1'b1;
                end
            end
            default:
            begin
                for (i = 0; i < n; i++)
                    model_bits[i] = (op == OP_SET_ALL);
                ans.accepted = 1'b1;
            end
        endcase
        return ans;
    endfunction

    task automatic note_failure(input string what, input answer_t want, input answer_t got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display({"%0t: %s: expected found %0d position %0d tally %0d accepted %0d,",
                      " got found %0d position %0d tally %0d accepted %0d"},
                     $time, what, want.found, want.position, want.tally, want.accepted,
                     got.found, got.position, got.tally, got.accepted);
    endtask

    // Result side: random stalls unless a steady stretch is running
    always @(posedge clk)
        out_ready <= steady_flow || ($urandom_range(99) >= 28);

    // Compare each result transfer with the oldest expectation
    always @(negedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {found, position, tally, accepted};
            results_seen++;
            if (pending_answers.size() == 0)
                note_failure("result with nothing outstanding", '0, got);
            else
            begin
                want = pending_answers.pop_front();
                if (got.found !== want.found || got.position !== want.position ||
                    got.tally !== want.tally || got.accepted !== want.accepted)
                    note_failure("result mismatch", want, got);
            end
        end
    end

    // Send one command and hold it until the transfer
    task automatic send_command(input op_t op, input logic [9:0] idx,
                                input logic [8:0] len, input logic val);
        while (!steady_flow && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        index      <= idx;
        run_length <= len;
        bit_value  <= val;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        pending_answers.push_back(apply_command(op, idx, len, val));
        op_seen[op]++;
        @(posedge clk);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bit_count(input logic [8:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        model_bit_count = value;
        cfg_writes++;
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed commands, with some out-of-range noise
    task automatic send_random_command();
        op_t        op;
        int         n;
        int         room;
        logic [9:0] idx;
        logic [8:0] len;
        n  = bits_in_use();
        op = op_t'($urandom_range(7));
        // keep whole-array fills rare so runs build varied patterns
        if ((op == OP_SET_ALL || op == OP_CLEAR_ALL) && $urandom_range(3) != 0)
            op = op_t'($urandom_range(5));
        if (n == 0 || $urandom_range(9) == 0)
            idx = 10'($urandom_range(1023));
        else
            idx = 10'($urandom_range(n - 1));
        room = n - int'(idx);
        if (room <= 0 || $urandom_range(9) == 0)
            len = 9'($urandom_range(511));
        else if ($urandom_range(2) == 0)
            len = 9'(room);
        else if ($urandom_range(1) == 0)
            len = 9'($urandom_range((room < 16) ? room : 16, 1));
        else
            len = 9'($urandom_range(room, 1));
        send_command(op, idx, len, 1'($urandom_range(1)));
    endtask

    task automatic test_directed_commands();
        send_command(OP_COUNT_ONES,  10'd0,    9'd0,   1'b0);
        send_command(OP_COUNT_ZEROS, 10'd0,    9'd0,   1'b0);
        send_command(OP_SEARCH_UP,   10'd0,    9'd0,   1'b1);
        send_command(OP_SEARCH_DOWN, 10'd1023, 9'd0,   1'b0);
        send_command(OP_SET_ALL,     10'd0,    9'd0,   1'b0);
        send_command(OP_COUNT_ONES,  10'd0,    9'd0,   1'b0);
        send_command(OP_CLEAR_ALL,   10'd0,    9'd0,   1'b0);
        send_command(OP_WRITE_RUN,   10'd0,    9'd1,   1'b1);
        send_command(OP_WRITE_RUN,   10'd255,  9'd1,   1'b1);
        send_command(OP_SEARCH_UP,   10'd1,    9'd0,   1'b1);
        send_command(OP_SEARCH_DOWN, 10'd254,  9'd0,   1'b1);
        // searches starting past the end
        send_command(OP_SEARCH_UP,   10'd256,  9'd0,   1'b0);
        send_command(OP_SEARCH_UP,   10'd1023, 9'd0,   1'b1);
        send_command(OP_FLIP_RUN,    10'd0,    9'd256, 1'b0);
        // refused runs: empty, too long, overrunning, starting past the end
        send_command(OP_WRITE_RUN,   10'd0,    9'd0,   1'b1);
        send_command(OP_WRITE_RUN,   10'd0,    9'd511, 1'b1);
        send_command(OP_FLIP_RUN,    10'd200,  9'd57,  1'b0);
        send_command(OP_WRITE_RUN,   10'd256,  9'd1,   1'b1);
        send_command(OP_WRITE_RUN,   10'd1023, 9'd256, 1'b0);
        send_command(OP_FLIP_RUN,    10'd3,    9'd10,  1'b1);
        send_command(OP_WRITE_RUN,   10'd7,    9'd2,   1'b0);
        send_command(OP_COUNT_ZEROS, 10'd0,    9'd0,   1'b0);
        send_command(OP_SEARCH_DOWN, 10'd1023, 9'd0,   1'b1);
        send_command(OP_SEARCH_UP,   10'd0,    9'd0,   1'b0);
    endtask

    task automatic test_bit_count_extremes();
        // partial last byte: fills leave the upper bits alone
        write_bit_count(9'd9);
        send_command(OP_SET_ALL,     10'd0,    9'd0,   1'b0);
        send_command(OP_COUNT_ONES,  10'd0,    9'd0,   1'b0);
        send_command(OP_SEARCH_UP,   10'd9,    9'd0,   1'b1);
        send_command(OP_WRITE_RUN,   10'd8,    9'd1,   1'b0);
        send_command(OP_WRITE_RUN,   10'd8,    9'd2,   1'b1);
        write_bit_count(9'd1);
        send_command(OP_COUNT_ZEROS, 10'd0,    9'd0,   1'b0);
        send_command(OP_SEARCH_DOWN, 10'd1023, 9'd0,   1'b1);
        send_command(OP_FLIP_RUN,    10'd0,    9'd1,   1'b0);
        send_command(OP_FLIP_RUN,    10'd0,    9'd2,   1'b0);
        // nothing in use
        write_bit_count(9'd0);
        send_command(OP_COUNT_ONES,  10'd0,    9'd0,   1'b0);
        send_command(OP_COUNT_ZEROS, 10'd0,    9'd0,   1'b0);
        send_command(OP_SEARCH_UP,   10'd0,    9'd0,   1'b0);
        send_command(OP_SEARCH_DOWN, 10'd1023, 9'd0,   1'b1);
        send_command(OP_WRITE_RUN,   10'd0,    9'd1,   1'b1);
        send_command(OP_SET_ALL,     10'd0,    9'd0,   1'b0);
        send_command(OP_CLEAR_ALL,   10'd0,    9'd0,   1'b0);
        // above the array size
        write_bit_count(9'd511);
        send_command(OP_COUNT_ZEROS, 10'd0,    9'd0,   1'b0);
        send_command(OP_SEARCH_DOWN, 10'd1023, 9'd0,   1'b0);
        send_command(OP_FLIP_RUN,    10'd250,  9'd6,   1'b0);
        send_command(OP_SET_ALL,     10'd0,    9'd0,   1'b0);
        send_command(OP_COUNT_ONES,  10'd0,    9'd0,   1'b0);
        write_bit_count(9'd256);
        send_command(OP_COUNT_ONES,  10'd0,    9'd0,   1'b0);
    endtask

    task automatic test_random_traffic();
        logic [8:0] setting;
        int         phase;
        int         k;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       setting = 9'd256;
                1:       setting = 9'($urandom_range(256, 1));
                2:       setting = 9'd511;
                3:       setting = 9'd9;
                4:       setting = 9'($urandom_range(511));
                default: setting = 9'd64;
            endcase
            write_bit_count(setting);
            for (k = 0; k < 230; k++)
                send_random_command();
        end
    endtask

    // Back-to-back stretch with no stalls on either side
    task automatic test_steady_stream();
        write_bit_count(9'($urandom_range(256, 1)));
        steady_flow = 1'b1;
        repeat (120) send_random_command();
        steady_flow = 1'b0;
    endtask

    // Sender holds off until the block has emptied, then resumes
    task automatic test_pause_until_empty();
        write_bit_count(9'd256);
        repeat (15) send_random_command();
        wait_idle();
        repeat (15) send_random_command();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_commands();
        test_bit_count_extremes();
        test_random_traffic();
        test_steady_stream();
        test_pause_until_empty();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            failures += pending_answers.size();
            $display("%0d results never arrived", pending_answers.size());
        end
        $display("Sent %0d counts, %0d searches, %0d runs, %0d fills over %0d bit_count writes",
                 op_seen[0] + op_seen[1], op_seen[2] + op_seen[3],
                 op_seen[4] + op_seen[5], op_seen[6] + op_seen[7], cfg_writes);
        $display("Checked %0d results, %0d failures", results_seen, failures);
        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
